[rtl/core/hid_keyboard_new_key_detect_unit_assert.svh]
// Assertion macros for the keyboard new-press detector.
`ifndef HID_KEYBOARD_NEW_KEY_DETECT_UNIT_ASSERT_SVH
`define HID_KEYBOARD_NEW_KEY_DETECT_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define HKD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hkd assertion failed: same-cycle implication");

`define HKD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hkd assertion failed: next-cycle implication");

`else

`define HKD_ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define HKD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/core/hkd_pkg.sv]
// Shared types, constants and the key code translation for the new-press detector.
package hkd_pkg;

  localparam int RPT_BYTES = 7;

  localparam logic [7:0] MIN_LEN  = 8'd3;
  localparam logic [7:0] BOOT_LEN = 8'd8;
  localparam logic [2:0] MAX_SLOTS = 3'd6;

  localparam logic [7:0] CODE_A     = 8'h04;
  localparam logic [7:0] CODE_Z     = 8'h1D;
  localparam logic [7:0] CODE_1     = 8'h1E;
  localparam logic [7:0] CODE_0     = 8'h27;
  localparam logic [7:0] CODE_ENTER = 8'h28;
  localparam logic [7:0] CODE_BKSP  = 8'h2A;
  localparam logic [7:0] CODE_SPACE = 8'h2C;

  localparam logic [6:0] CHR_A     = 7'h61;
  localparam logic [6:0] CHR_1     = 7'h31;
  localparam logic [6:0] CHR_0     = 7'h30;
  localparam logic [6:0] CHR_SPACE = 7'h20;
  localparam logic [6:0] CHR_NL    = 7'h0A;
  localparam logic [6:0] CHR_BS    = 7'h08;
  localparam logic [6:0] CHR_NONE  = 7'h00;

  typedef struct packed {
    logic [7:0] code;
    logic [6:0] ascii;
  } hkd_key_t;

  typedef struct packed {
    logic [7:0] code;
    logic [6:0] ascii;
    logic       last;
  } hkd_res_t;

  function automatic logic [6:0] to_ascii(input logic [7:0] code);
    logic [6:0] chr;
    if (code >= CODE_A && code <= CODE_Z) begin
      chr = CHR_A + 7'(code - CODE_A);
    end else if (code == CODE_0) begin
      chr = CHR_0;
    end else if (code >= CODE_1 && code < CODE_0) begin
      chr = CHR_1 + 7'(code - CODE_1);
    end else if (code == CODE_SPACE) begin
      chr = CHR_SPACE;
    end else if (code == CODE_ENTER) begin
      chr = CHR_NL;
    end else if (code == CODE_BKSP) begin
      chr = CHR_BS;
    end else begin
      chr = CHR_NONE;
    end
    return chr;
  endfunction

endpackage

[rtl/core/hkd_if.sv]
// Valid/ready channel interfaces for report items and press items.
interface hkd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] report_length;
  logic [7:0] report_byte2;
  logic [7:0] report_byte3;
  logic [7:0] report_byte4;
  logic [7:0] report_byte5;
  logic [7:0] report_byte6;
  logic [7:0] report_byte7;
  logic [7:0] report_byte8;

  modport source (
    output valid, report_length, report_byte2, report_byte3, report_byte4,
           report_byte5, report_byte6, report_byte7, report_byte8,
    input  ready
  );
  modport sink (
    input  valid, report_length, report_byte2, report_byte3, report_byte4,
           report_byte5, report_byte6, report_byte7, report_byte8,
    output ready
  );
endinterface

interface hkd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_code;
  logic [6:0] ascii_char;
  logic       last_press;

  modport source (output valid, key_code, ascii_char, last_press, input ready);
  modport sink (input valid, key_code, ascii_char, last_press, output ready);
endinterface

[rtl/core/hkd_lane.sv]
// One slot lane: match the slot code against the stored codes and translate it.
module hkd_lane import hkd_pkg::*; #(
  parameter int KEY_SLOTS = 6
) (
  input  logic [7:0]                 code,
  input  logic [KEY_SLOTS-1:0][7:0]  prev,
  output hkd_key_t                   key,
  output logic                       fresh
);

  logic [KEY_SLOTS-1:0] hit;

  always_comb begin
    for (int j = 0; j < KEY_SLOTS; j++) begin
      hit[j] = (prev[j] == code);
    end
    fresh     = (code != 8'h00) && !(|hit);
    key.code  = code;
    key.ascii = to_ascii(code);
  end

endmodule

[rtl/core/hkd_merge.sv]
// Merge stage: hold the lanes' fresh mask and emit one press per cycle in slot order while the output is ready.
module hkd_merge import hkd_pkg::*; #(
  parameter int KEY_SLOTS = 6
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  hkd_key_t [KEY_SLOTS-1:0]      keys,
  input  logic [KEY_SLOTS-1:0]          fresh,
  output logic                          can_load,
  output hkd_res_t                      res,
  output logic                          res_valid,
  input  logic                          res_ready
);

  hkd_key_t [KEY_SLOTS-1:0] keys_r, keys_nxt;
  logic [KEY_SLOTS-1:0]     mask_r, mask_nxt;
  logic [KEY_SLOTS-1:0]     pick, rest;
  hkd_res_t                 res_r, res_nxt;
  logic                     valid_r, valid_nxt;
  logic                     advance;
  hkd_key_t                 sel;

  always_comb begin
    pick    = mask_r & (~mask_r + 1'b1);
    rest    = mask_r & ~pick;
    advance = (|mask_r) && (!valid_r || res_ready);
    sel     = '0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      sel = sel | (keys_r[i] & {$bits(hkd_key_t){pick[i]}});
    end
    // free once the last pending press moves into the output register
    can_load = !(|mask_r) || (advance && !(|rest));

    mask_nxt = load ? fresh : (advance ? rest : mask_r);
    keys_nxt = load ? keys : keys_r;

    valid_nxt = advance ? 1'b1 : (res_ready ? 1'b0 : valid_r);
    res_nxt   = res_r;
    if (advance) begin
      res_nxt.code  = sel.code;
      res_nxt.ascii = sel.ascii;
      res_nxt.last  = !(|rest);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      mask_r  <= mask_nxt;
      valid_r <= valid_nxt;
    end
    keys_r <= keys_nxt;
    res_r  <= res_nxt;
  end

  assign res       = res_r;
  assign res_valid = valid_r;

endmodule

[rtl/core/hid_keyboard_new_key_detect_unit.sv]
// Keyboard new-press detector: each input item is one report (length and bytes 2 to 8).
// All KEY_SLOTS slot codes are checked against the stored codes of the previous report in
// parallel lanes in the accept cycle, and the store is replaced at once, so a report can be
// taken every cycle as far as the lanes go. Presses leave through an output register one per
// cycle in slot order while the output is ready; the next report is taken in the cycle the
// last press moves to the output. Reports shorter than 3 bytes are taken and dropped. No
// clearing pass: the store resets at once.
`include "hid_keyboard_new_key_detect_unit_assert.svh"

module hid_keyboard_new_key_detect_unit import hkd_pkg::*; #(
  parameter int KEY_SLOTS = 6
) (
  input logic        clk,
  input logic        rst_n,
  hkd_in_if.sink     in_chan,
  hkd_out_if.source  out_chan
);

  localparam logic [2:0] SLOT_CAP = 3'(KEY_SLOTS);

  logic [KEY_SLOTS-1:0][7:0] prev_r, prev_nxt;
  logic [KEY_SLOTS-1:0][7:0] slots;
  logic [7:0]                rpt_bytes [RPT_BYTES];
  hkd_key_t [KEY_SLOTS-1:0]  lane_keys;
  logic [KEY_SLOTS-1:0]      lane_fresh;
  logic                      report_ok, boot_len, accept, load, can_load;
  logic [2:0]                base_cnt, slot_cnt;
  hkd_res_t                  res;
  logic                      res_valid;

  always_comb begin
    rpt_bytes[0] = in_chan.report_byte2;
    rpt_bytes[1] = in_chan.report_byte3;
    rpt_bytes[2] = in_chan.report_byte4;
    rpt_bytes[3] = in_chan.report_byte5;
    rpt_bytes[4] = in_chan.report_byte6;
    rpt_bytes[5] = in_chan.report_byte7;
    rpt_bytes[6] = in_chan.report_byte8;

    report_ok = in_chan.report_length >= MIN_LEN;
    boot_len  = in_chan.report_length == BOOT_LEN;
    base_cnt  = (in_chan.report_length >= BOOT_LEN) ? MAX_SLOTS
                                                    : 3'(in_chan.report_length - MIN_LEN);
    slot_cnt  = (base_cnt > SLOT_CAP) ? SLOT_CAP : base_cnt;

    // boot-length reports start at byte 2, all others at byte 3
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (3'(i) < slot_cnt) begin
        slots[i] = boot_len ? rpt_bytes[i] : rpt_bytes[i + 1];
      end else begin
        slots[i] = '0;
      end
    end

    accept   = in_chan.valid && in_chan.ready;
    load     = accept && report_ok;
    prev_nxt = load ? slots : prev_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else begin
      prev_r <= prev_nxt;
    end
  end

  for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_lane
    hkd_lane #(.KEY_SLOTS(KEY_SLOTS)) u_lane (
      .code  (slots[g]),
      .prev  (prev_r),
      .key   (lane_keys[g]),
      .fresh (lane_fresh[g])
    );
  end

  hkd_merge #(.KEY_SLOTS(KEY_SLOTS)) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .keys      (lane_keys),
    .fresh     (lane_fresh),
    .can_load  (can_load),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (out_chan.ready)
  );

  assign in_chan.ready       = can_load;
  assign out_chan.valid      = res_valid;
  assign out_chan.key_code   = res.code;
  assign out_chan.ascii_char = res.ascii;
  assign out_chan.last_press = res.last;

  `HKD_ASSERT_IMPLY(a_code_nonzero, clk, rst_n, out_chan.valid, out_chan.key_code != 8'h00)
  `HKD_ASSERT_NEXT(a_short_keeps_store, clk, rst_n, accept && !report_ok, $stable(prev_r))
  `HKD_ASSERT_NEXT(a_more_follow, clk, rst_n, out_chan.valid && out_chan.ready && !out_chan.last_press, out_chan.valid)

endmodule
